/* hdl/vna_pkg.sv */
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants of the vector normalize affine unit
// Element record, arithmetic widths and the request format of the iterative
// divide and square root unit.
// ----------------------------------------------------------------------------
package vna_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;

	localparam int IN_W   = 16;
	localparam int X_W    = 18;
	localparam int SUM_W  = 24;
	localparam int CNT_W  = 7;
	localparam int IDX_W  = 6;
	localparam int DM_W   = 24;
	localparam int MUL_W  = 24;
	localparam int PROD_W = 2 * MUL_W;
	localparam int Q_W    = 54;
	localparam int WORD_W = 64;
	localparam int DEN_W  = 32;
	localparam int RSD_W  = 37;
	localparam int M_W    = 41;
	localparam int CNTI_W = 6;

	localparam logic OP_DIV  = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	typedef struct packed {
		logic signed [X_W-1:0]  x;
		logic signed [IN_W-1:0] g;
		logic signed [IN_W-1:0] b;
	} elem_t;

	typedef struct packed {
		logic              start;
		logic              op;
		logic [WORD_W-1:0] arg;
		logic [DEN_W-1:0]  divisor;
	} iter_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [WORD_W-1:0] result;
	} iter_rsp_t;

endpackage

/* hdl/vna_store.sv */
// ----------------------------------------------------------------------------
// vna_store: element memory
// Holds the sum, scale and offset of every element, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module vna_store
	import vna_pkg::*;
#(
	parameter int DEPTH = MAX_ELEMENTS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  elem_t         wdata,
	input  logic [AW-1:0] raddr,
	output elem_t         rdata
);

	elem_t mem_q [DEPTH];
	elem_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/vna_mul.sv */
// ----------------------------------------------------------------------------
// vna_mul: shared multiplier
// Unsigned 24 by 24 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
module vna_mul
	import vna_pkg::*;
(
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

/* hdl/vna_iter.sv */
// ----------------------------------------------------------------------------
// vna_iter: iterative divide and square root unit
// Restoring division one quotient bit per cycle, and the bitwise integer
// square root one result bit per cycle.
// ----------------------------------------------------------------------------
module vna_iter
	import vna_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  iter_req_t req,
	output iter_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [CNTI_W-1:0] cnt_q;
	logic              op_q;
	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] res_q;
	logic [WORD_W-1:0] bit_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;

	logic [DEN_W:0]    rem_sh;
	logic              div_ge;
	logic [DEN_W:0]    rem_nx;
	logic [WORD_W-1:0] sq_t;
	logic              sq_ge;

	always_comb begin
		rem_sh = {rem_q, num_q[WORD_W-1]};
		div_ge = rem_sh >= {1'b0, den_q};
		rem_nx = div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
		sq_t   = res_q + bit_q;
		sq_ge  = num_q >= sq_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_DIV) ? CNTI_W'(WORD_W - 1) : CNTI_W'(WORD_W / 2 - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			num_q <= req.arg;
			den_q <= req.divisor;
			rem_q <= '0;
			res_q <= '0;
			bit_q <= WORD_W'(1) << (WORD_W - 2);
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				rem_q <= rem_nx[DEN_W-1:0];
				num_q <= {num_q[WORD_W-2:0], 1'b0};
				res_q <= {res_q[WORD_W-2:0], div_ge};
			end else begin
				if (sq_ge) begin
					num_q <= num_q - sq_t;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

/* hdl/vector_normalize_affine_unit.sv */
// ----------------------------------------------------------------------------
// vector_normalize_affine_unit: layer normalisation of one vector
// Loads elements, then normalises, scales and offsets them in fixed point.
// ----------------------------------------------------------------------------
// Each input transaction loads one element, and the block stays ready for the
// next one. The element that completes the vector starts the computation,
// during which the input is stalled: a variance pass that reads, differences,
// squares and accumulates each element on the shared multiplier, a division,
// a square root and, unless the square root is zero, a second division, then
// an output pass that reads, differences, scales and offsets each element and
// holds while the output is stalled.
module vector_normalize_affine_unit
	import vna_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CNT_W-1:0]       cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [IN_W-1:0] x_val,
	input  logic signed [IN_W-1:0] v_val,
	input  logic signed [IN_W-1:0] b_val,
	input  logic signed [IN_W-1:0] gamma_scale,
	input  logic signed [IN_W-1:0] beta_shift,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [IN_W-1:0] y_val,
	output logic [IDX_W-1:0]       elem_index,
	output logic                   last_elem,
	output logic                   saturated
);

	localparam int AW = $clog2(MAX_ELEMENTS);

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_RD1  = 5'd1;
	localparam logic [4:0] ST_D1   = 5'd2;
	localparam logic [4:0] ST_SQ   = 5'd3;
	localparam logic [4:0] ST_ACC  = 5'd4;
	localparam logic [4:0] ST_DIVW = 5'd5;
	localparam logic [4:0] ST_SQRT = 5'd6;
	localparam logic [4:0] ST_DIVR = 5'd7;
	localparam logic [4:0] ST_RD2  = 5'd8;
	localparam logic [4:0] ST_D2   = 5'd9;
	localparam logic [4:0] ST_M1   = 5'd10;
	localparam logic [4:0] ST_M2   = 5'd11;
	localparam logic [4:0] ST_M3   = 5'd12;
	localparam logic [4:0] ST_M4   = 5'd13;
	localparam logic [4:0] ST_M5   = 5'd14;
	localparam logic [4:0] ST_M6   = 5'd15;
	localparam logic [4:0] ST_OUT  = 5'd16;

	logic [4:0]              state_q;
	logic [CNT_W-1:0]        vec_size_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        n_q;
	logic [AW-1:0]           i_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] tot_q;
	logic [Q_W-1:0]          q_q;
	logic [RSD_W-1:0]        rsd_q;
	logic [DM_W-1:0]         dm_q;
	logic                    neg_q;
	logic [IN_W-1:0]         gm_q;
	logic signed [IN_W-1:0]  beta_q;
	logic [PROD_W-1:0]       macc_q;
	logic [M_W-1:0]          m_q;
	iter_req_t               req_q;
	logic                    out_valid_q;
	logic signed [IN_W-1:0]  y_q;
	logic                    sat_q;

	iter_rsp_t               rsp;
	elem_t                   wdata;
	elem_t                   rdata;
	logic [MUL_W-1:0]        mul_a;
	logic [MUL_W-1:0]        mul_b;
	logic [PROD_W-1:0]       prod;

	logic                    in_acc;
	logic                    out_acc;
	logic [CNT_W-1:0]        lim;
	logic [CNT_W-1:0]        cnt_nx;
	logic signed [X_W-1:0]   xs;
	logic signed [SUM_W-1:0] sum_nx;
	logic signed [25:0]      nx;
	logic signed [25:0]      d;
	logic [25:0]             dabs;
	logic                    i_last;
	logic [61:0]             m_full;
	logic [57:0]             p_full;
	logic signed [27:0]      y_full;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;

	always_comb begin
		if (vec_size_q < CNT_W'(2)) begin
			lim = CNT_W'(2);
		end else if (vec_size_q > CNT_W'(MAX_ELEMENTS)) begin
			lim = CNT_W'(MAX_ELEMENTS);
		end else begin
			lim = vec_size_q;
		end
		cnt_nx  = cnt_q + 1'b1;
		xs      = X_W'(x_val) + X_W'(v_val) + X_W'(b_val);
		sum_nx  = sum_q + SUM_W'(xs);
		wdata.x = xs;
		wdata.g = gamma_scale;
		wdata.b = beta_shift;
		nx      = $signed({1'b0, n_q}) * rdata.x;
		d       = nx - 26'(tot_q);
		dabs    = d[25] ? 26'(-d) : 26'(d);
		i_last  = CNT_W'(i_q) == n_q - 1'b1;
		m_full  = 62'(macc_q) + (62'(prod) << 19);
		p_full  = (58'(macc_q) + (58'(prod) << 24) + (58'(1) << 31)) >> 32;
		y_full  = neg_q ? -28'(p_full[25:0]) : 28'(p_full[25:0]);
		y_full  = y_full + 28'(beta_q);
	end

	always_comb begin
		mul_a = dm_q;
		mul_b = dm_q;
		unique case (state_q)
			ST_M1: mul_b = MUL_W'(rsd_q[18:0]);
			ST_M2: mul_b = MUL_W'(rsd_q[RSD_W-1:19]);
			ST_M4: begin
				mul_a = m_q[23:0];
				mul_b = MUL_W'(gm_q);
			end
			ST_M5: begin
				mul_a = MUL_W'(m_q[M_W-1:24]);
				mul_b = MUL_W'(gm_q);
			end
			default: mul_b = dm_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vec_size_q  <= CNT_W'(MAX_ELEMENTS_DEF);
			cnt_q       <= '0;
			sum_q       <= '0;
			req_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			req_q.start <= 1'b0;
			if (cfg_wr_en) begin
				vec_size_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cnt_nx >= lim) begin
							cnt_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_RD1;
						end else begin
							cnt_q <= cnt_nx;
							sum_q <= sum_nx;
						end
					end
				end
				ST_RD1:  state_q <= ST_D1;
				ST_D1:   state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ACC;
				ST_ACC: begin
					if (i_last) begin
						req_q.start   <= 1'b1;
						req_q.op      <= OP_DIV;
						req_q.arg     <= WORD_W'(q_q + Q_W'(prod));
						req_q.divisor <= DEN_W'(n_q - 1'b1);
						state_q       <= ST_DIVW;
					end else begin
						state_q <= ST_RD1;
					end
				end
				ST_DIVW: begin
					if (rsp.done) begin
						req_q.start <= 1'b1;
						req_q.op    <= OP_SQRT;
						req_q.arg   <= rsp.result << 8;
						state_q     <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (rsp.done) begin
						if (rsp.result[DEN_W-1:0] == '0) begin
							state_q <= ST_RD2;
						end else begin
							req_q.start   <= 1'b1;
							req_q.op      <= OP_DIV;
							req_q.arg     <= WORD_W'(1) << (RSD_W - 1);
							req_q.divisor <= rsp.result[DEN_W-1:0];
							state_q       <= ST_DIVR;
						end
					end
				end
				ST_DIVR: begin
					if (rsp.done) begin
						state_q <= ST_RD2;
					end
				end
				ST_RD2:  state_q <= ST_D2;
				ST_D2:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_M6;
				ST_M6: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						state_q     <= i_last ? ST_IDLE : ST_RD2;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					i_q   <= '0;
					q_q   <= '0;
					n_q   <= cnt_nx;
					tot_q <= sum_nx;
				end
			end
			ST_D1: dm_q <= dabs[DM_W-1:0];
			ST_ACC: begin
				q_q <= q_q + Q_W'(prod);
				i_q <= i_last ? '0 : i_q + 1'b1;
			end
			ST_SQRT: begin
				if (rsp.done) begin
					rsd_q <= RSD_W'(1) << (RSD_W - 1);
				end
			end
			ST_DIVR: begin
				if (rsp.done) begin
					rsd_q <= rsp.result[RSD_W-1:0];
				end
			end
			ST_D2: begin
				dm_q   <= dabs[DM_W-1:0];
				neg_q  <= d[25] != rdata.g[IN_W-1];
				gm_q   <= rdata.g[IN_W-1] ? IN_W'(-rdata.g) : IN_W'(rdata.g);
				beta_q <= rdata.b;
			end
			ST_M2: macc_q <= prod;
			ST_M3: begin
				if (m_full > (62'(1) << 40)) begin
					m_q <= M_W'(1) << 40;
				end else begin
					m_q <= m_full[M_W-1:0];
				end
			end
			ST_M5: macc_q <= prod;
			ST_M6: begin
				if (y_full > 28'sd32767) begin
					y_q   <= 16'sh7fff;
					sat_q <= 1'b1;
				end else if (y_full < -28'sd32768) begin
					y_q   <= 16'sh8000;
					sat_q <= 1'b1;
				end else begin
					y_q   <= y_full[IN_W-1:0];
					sat_q <= 1'b0;
				end
			end
			ST_OUT: begin
				if (out_acc && !i_last) begin
					i_q <= i_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	vna_store #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (in_acc),
		.waddr (cnt_q[AW-1:0]),
		.wdata (wdata),
		.raddr (i_q),
		.rdata (rdata)
	);

	vna_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	vna_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign in_stall   = state_q != ST_IDLE;
	assign out_valid  = out_valid_q;
	assign y_val      = y_q;
	assign elem_index = IDX_W'(i_q);
	assign last_elem  = i_last;
	assign saturated  = sat_q;

	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("Result offered while input is open.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_ELEMENTS))
		else $error("Element count reached the store depth.");

	a_iter_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !rsp.busy)
		else $error("Divide unit busy during the output pass.");

	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_elem && !out_stall |=> !in_stall)
		else $error("Block did not return to loading after the last result.");

endmodule
